// ===== rtl/ffha_pkg.sv =====
// Package: shared types, constants and codes for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_ZERO     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_HEAP_START = 1'b0;
    localparam logic REG_HEAP_SIZE  = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_SCAN_WAIT,
        S_ALLOC_SHIFT,
        S_ALLOC_SHIFT_WAIT,
        S_ALLOC_WRITE,
        S_FREE_MARK,
        S_FREE_PREV,
        S_FREE_CHECK,
        S_FREE_NEXT,
        S_REMOVE,
        S_REMOVE_WAIT,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic init;      // rebuild table from config
        logic latch;     // capture input transaction
        logic prep;      // compute need, clear scan index
        logic rd_scan;   // issue read of entry at scan index
        logic step;      // advance scan index
        logic match;     // record hit at scan index
        logic sh_rd;     // read entry below shift index
        logic sh_wr;     // write read data one slot up (split)
        logic split_wr;  // write split-off remainder entry
        logic grant_whole; // write hit entry, mark in use
        logic fr_mark;   // mark freed block, update total, read previous entry
        logic fr_prev;   // merge into previous
        logic fr_rd_next; // read entry after hit
        logic fr_next;   // merge next
        logic fr_write;  // write merged entry back at hit
        logic rm_rd;
        logic rm_wr;
        logic finish;    // load result register
        logic fail;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       zero_req;
        logic       is_free;
        logic       scan_end;
        logic       hit;
        logic       do_split;
        logic       sh_end;
        logic       fr_bad;
        logic       prev_free;
        logic       next_free;
        logic       rm_end;
        logic [1:0] fail_code;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/ffha_if.sv =====
// Interfaces: valid/ready channels for requests and results.
`default_nettype none
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] request_size;
    logic [12:0] alignment;
    logic [31:0] release_addr;
    modport source (output valid, kind, request_size, alignment, release_addr, input ready);
    modport sink (input valid, kind, request_size, alignment, release_addr, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] block_addr;
    logic [31:0] used_bytes;
    logic [31:0] free_bytes;
    modport source (output valid, status, block_addr, used_bytes, free_bytes, input ready);
    modport sink (input valid, status, block_addr, used_bytes, free_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ffha_datapath.sv =====
// Datapath: block table, scan index, request arithmetic and result register.
`default_nettype none
module ffha_datapath #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ffha_pkg::cmd_t   cmd,
    output ffha_pkg::stat_t       stat,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [31:0]      cfg_data,
    input  wire logic             in_kind,
    input  wire logic [31:0]      in_request_size,
    input  wire logic [12:0]      in_alignment,
    input  wire logic [31:0]      in_release_addr,
    output logic [1:0]            res_status,
    output logic [31:0]           res_block_addr,
    output logic [31:0]           res_used_bytes,
    output logic [31:0]           res_free_bytes
);
    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);
    localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] CONE = CW'(1);

    logic [31:0] heap_start_reg, heap_size_reg;
    logic [31:0] heap_start_next, heap_size_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] used_reg, used_next;
    logic [MAX_BLOCKS-1:0] inuse_reg, inuse_next;
    logic        kind_reg;
    logic [31:0] size_reg, addr_reg;
    logic [12:0] align_reg;
    logic [33:0] need_reg, need_next;
    logic [CW-1:0] idx_reg, idx_next;   // scan / shift / remove index
    logic [CW-1:0] hit_reg, hit_next;
    logic [31:0] hstart_reg, hsize_reg; // entry at hit
    logic [31:0] hstart_next, hsize_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] ba_reg, ba_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wstart, wsize, rstart, rsize;

    ffha_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_start (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wstart), .raddr(raddr), .rdata(rstart));
    ffha_ram #(.WIDTH(32), .DEPTH(MAX_BLOCKS)) u_size (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wsize), .raddr(raddr), .rdata(rsize));

    logic [33:0] want;
    logic [AW-1:0] idx_a, hit_a;
    logic [CW-1:0] idx_m1;
    logic [31:0] am, n32;
    logic        rd_inuse;

    always_comb
    begin
        want = {2'b00, size_reg};
        if (align_reg != 13'd0)
        begin
            want = {2'b00, size_reg} + {21'd0, align_reg} - 34'd1;
        end
        idx_a = idx_reg[AW-1:0];
        hit_a = hit_reg[AW-1:0];
        idx_m1 = idx_reg - CONE;
        am = {19'd0, align_reg} - 32'd1;
        n32 = need_reg[31:0];
        rd_inuse = inuse_reg[idx_m1[AW-1:0]];
    end

    // RAM port control
    always_comb
    begin
        we = 1'b0;
        waddr = hit_a;
        wstart = hstart_reg;
        wsize = hsize_reg;
        raddr = idx_a;
        if (cmd.init)
        begin
            we = 1'b1;
            waddr = '0;
            wstart = heap_start_reg + HDR;
            wsize = (heap_size_reg >= HDR) ? heap_size_reg - HDR : 32'd0;
        end
        else if (cmd.sh_rd)
        begin
            raddr = idx_m1[AW-1:0];
        end
        else if (cmd.sh_wr)
        begin
            we = 1'b1;
            waddr = idx_a;
            wstart = rstart;
            wsize = rsize;
        end
        else if (cmd.split_wr)
        begin
            // remainder goes one slot above the hit; the hit itself is written on grant
            we = 1'b1;
            waddr = AW'(hit_reg + CONE);
            wstart = hstart_reg + n32 + HDR;
            wsize = hsize_reg - n32 - HDR;
        end
        else if (cmd.fr_write || cmd.grant_whole)
        begin
            we = 1'b1;
            waddr = hit_a;
        end
        else if (cmd.fr_mark)
        begin
            raddr = AW'(hit_reg - CONE);
        end
        else if (cmd.fr_rd_next)
        begin
            raddr = AW'(hit_reg + CONE);
        end
        else if (cmd.rm_rd)
        begin
            raddr = AW'(idx_reg + CONE);
        end
        else if (cmd.rm_wr)
        begin
            we = 1'b1;
            waddr = idx_a;
            wstart = rstart;
            wsize = rsize;
        end
    end

    always_comb
    begin
        heap_start_next = heap_start_reg;
        heap_size_next = heap_size_reg;
        count_next = count_reg;
        used_next = used_reg;
        inuse_next = inuse_reg;
        need_next = need_reg;
        idx_next = idx_reg;
        hit_next = hit_reg;
        hstart_next = hstart_reg;
        hsize_next = hsize_reg;
        st_next = st_reg;
        ba_next = ba_reg;
        if (cfg_we)
        begin
            if (cfg_index == ffha_pkg::REG_HEAP_START)
                heap_start_next = cfg_data;
            else
                heap_size_next = cfg_data;
        end
        if (cmd.init)
        begin
            count_next = CONE;
            used_next = '0;
            inuse_next = '0;
        end
        if (cmd.prep)
        begin
            need_next = (want + 34'd3) & ~34'd3;
            idx_next = '0;
        end
        if (cmd.step)
            idx_next = idx_reg + CONE;
        if (cmd.match)
        begin
            hit_next = idx_m1;
            hstart_next = rstart;
            hsize_next = rsize;
            idx_next = count_reg; // shift index for split
        end
        if (cmd.sh_wr)
        begin
            inuse_next[idx_a] = rd_inuse;
            idx_next = idx_m1;
        end
        if (cmd.split_wr)
        begin
            inuse_next[AW'(hit_reg + CONE)] = 1'b0;
            count_next = count_reg + CONE;
            hsize_next = n32;
        end
        if (cmd.grant_whole)
        begin
            inuse_next[hit_a] = 1'b1;
            used_next = used_reg + hsize_reg;
            ba_next = (align_reg != 13'd0) ? ((hstart_reg + am) & ~am) : hstart_reg;
            st_next = ffha_pkg::ST_OK;
        end
        if (cmd.fr_mark)
        begin
            inuse_next[hit_a] = 1'b0;
            used_next = used_reg - hsize_reg;
            ba_next = '0;
            st_next = ffha_pkg::ST_OK;
        end
        if (cmd.fr_prev)
        begin
            hit_next = hit_reg - CONE;
            hstart_next = rstart;
            hsize_next = rsize + hsize_reg + HDR;
            idx_next = hit_reg;
        end
        if (cmd.fr_next)
        begin
            hsize_next = hsize_reg + rsize + HDR;
            idx_next = hit_reg + CONE;
        end
        if (cmd.rm_wr)
        begin
            inuse_next[idx_a] = inuse_reg[AW'(idx_reg + CONE)];
            idx_next = idx_reg + CONE;
        end
        if (cmd.rm_rd && (idx_reg + CONE >= count_reg))
            count_next = count_reg - CONE;
        if (cmd.fail)
        begin
            st_next = stat.fail_code;
            ba_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= '0;
            heap_size_reg <= '0;
            count_reg <= CONE;
            used_reg <= '0;
            inuse_reg <= '0;
        end
        else
        begin
            heap_start_reg <= heap_start_next;
            heap_size_reg <= heap_size_next;
            count_reg <= count_next;
            used_reg <= used_next;
            inuse_reg <= inuse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg <= in_kind;
            size_reg <= in_request_size;
            align_reg <= in_alignment;
            addr_reg <= in_release_addr;
        end
        need_reg <= need_next;
        idx_reg <= idx_next;
        hit_reg <= hit_next;
        hstart_reg <= hstart_next;
        hsize_reg <= hsize_next;
        st_reg <= st_next;
        ba_reg <= ba_next;
        if (cmd.finish)
        begin
            res_status <= st_next;
            res_block_addr <= ba_next;
            res_used_bytes <= used_next;
            res_free_bytes <= heap_size_reg - used_next;
        end
    end

    // Status to controller. rd data valid for entry idx-1 in SCAN_WAIT.
    always_comb
    begin
        stat.zero_req = (kind_reg == ffha_pkg::KIND_FREE) ? (addr_reg == 32'd0) :
                        (want == 34'd0);
        stat.is_free = (kind_reg == ffha_pkg::KIND_FREE);
        stat.scan_end = (idx_reg >= count_reg);
        if (kind_reg == ffha_pkg::KIND_FREE)
            stat.hit = (rstart == addr_reg);
        else
            stat.hit = !rd_inuse && ({2'b00, rsize} >= need_reg);
        stat.do_split = ({2'b00, hsize_reg} > need_reg + {2'b00, HDR}) && (count_reg < CMAX);
        stat.sh_end = (idx_reg <= hit_reg + CONE);
        stat.fr_bad = !inuse_reg[hit_a];
        stat.prev_free = (hit_reg != '0) && !inuse_reg[AW'(hit_reg - CONE)];
        stat.next_free = (hit_reg + CONE < count_reg) && !inuse_reg[AW'(hit_reg + CONE)];
        stat.rm_end = (idx_reg + CONE >= count_reg);
        stat.fail_code = (kind_reg == ffha_pkg::KIND_FREE) ? ffha_pkg::ST_NOTFOUND :
                         ffha_pkg::ST_NOFIT;
        if (kind_reg == ffha_pkg::KIND_ALLOC && want == 34'd0)
            stat.fail_code = ffha_pkg::ST_ZERO;
        if (kind_reg == ffha_pkg::KIND_FREE && addr_reg == 32'd0)
            stat.fail_code = ffha_pkg::ST_NOTFOUND;
    end
endmodule
`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// Controller: sequences scan, split shift, merge and entry removal.
`default_nettype none
module ffha_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire ffha_pkg::stat_t stat,
    output ffha_pkg::cmd_t       cmd
);
    ffha_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic merged_reg, merged_next;   // next merge done, only write-back pending

    always_comb
    begin
        state_next = state_reg;
        merged_next = merged_reg;
        case (state_reg)
            ffha_pkg::S_INIT: state_next = ffha_pkg::S_IDLE;
            ffha_pkg::S_IDLE:
                if (in_valid && !out_valid_reg) state_next = ffha_pkg::S_PREP;
            ffha_pkg::S_PREP:
                if (stat.zero_req) state_next = ffha_pkg::S_DONE;
                else state_next = ffha_pkg::S_SCAN;
            ffha_pkg::S_SCAN:
                if (stat.scan_end) state_next = ffha_pkg::S_DONE;
                else state_next = ffha_pkg::S_SCAN_WAIT;
            ffha_pkg::S_SCAN_WAIT:
                if (stat.hit) state_next = stat.is_free ? ffha_pkg::S_FREE_MARK :
                                                         ffha_pkg::S_ALLOC_SHIFT;
                else state_next = ffha_pkg::S_SCAN;
            ffha_pkg::S_ALLOC_SHIFT:
                if (!stat.do_split || stat.sh_end) state_next = ffha_pkg::S_ALLOC_WRITE;
                else state_next = ffha_pkg::S_ALLOC_SHIFT_WAIT;
            ffha_pkg::S_ALLOC_SHIFT_WAIT: state_next = ffha_pkg::S_ALLOC_SHIFT;
            // split write first, then the grant once the hit is cut down
            ffha_pkg::S_ALLOC_WRITE:
                if (!stat.do_split) state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_FREE_MARK:
            begin
                merged_next = 1'b0;
                if (stat.fr_bad) state_next = ffha_pkg::S_DONE;
                else if (stat.prev_free) state_next = ffha_pkg::S_FREE_PREV;
                else state_next = ffha_pkg::S_FREE_CHECK;
            end
            ffha_pkg::S_FREE_PREV: state_next = ffha_pkg::S_REMOVE;
            ffha_pkg::S_FREE_CHECK:
                if (!merged_reg && stat.next_free) state_next = ffha_pkg::S_FREE_NEXT;
                else state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_FREE_NEXT:
            begin
                merged_next = 1'b1;
                state_next = ffha_pkg::S_REMOVE;
            end
            ffha_pkg::S_REMOVE:
                if (stat.rm_end) state_next = ffha_pkg::S_FREE_CHECK;
                else state_next = ffha_pkg::S_REMOVE_WAIT;
            ffha_pkg::S_REMOVE_WAIT: state_next = ffha_pkg::S_REMOVE;
            ffha_pkg::S_DONE: state_next = ffha_pkg::S_IDLE;
            default: state_next = ffha_pkg::S_IDLE;
        endcase
        if (cfg_we) state_next = ffha_pkg::S_INIT;
    end

    always_comb
    begin
        cmd = '0;
        in_ready = (state_reg == ffha_pkg::S_IDLE) && !out_valid_reg && !cfg_we;
        case (state_reg)
            ffha_pkg::S_INIT: cmd.init = 1'b1;
            ffha_pkg::S_IDLE: cmd.latch = in_ready;
            ffha_pkg::S_PREP:
            begin
                cmd.prep = 1'b1;
                if (stat.zero_req) cmd.fail = 1'b1;
            end
            ffha_pkg::S_SCAN:
                if (stat.scan_end)
                begin
                    cmd.fail = 1'b1;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    cmd.step = 1'b1;
                end
            ffha_pkg::S_SCAN_WAIT:
                if (stat.hit) cmd.match = 1'b1;
            ffha_pkg::S_ALLOC_SHIFT:
                if (stat.do_split && !stat.sh_end) cmd.sh_rd = 1'b1;
            ffha_pkg::S_ALLOC_SHIFT_WAIT: cmd.sh_wr = 1'b1;
            ffha_pkg::S_ALLOC_WRITE:
                if (stat.do_split) cmd.split_wr = 1'b1;
                else cmd.grant_whole = 1'b1;
            ffha_pkg::S_FREE_MARK:
                if (stat.fr_bad) cmd.fail = 1'b1;
                else cmd.fr_mark = 1'b1;
            ffha_pkg::S_FREE_PREV: cmd.fr_prev = 1'b1;
            ffha_pkg::S_FREE_CHECK:
                if (!merged_reg && stat.next_free) cmd.fr_rd_next = 1'b1;
                else cmd.fr_write = 1'b1;
            ffha_pkg::S_FREE_NEXT: cmd.fr_next = 1'b1;
            ffha_pkg::S_REMOVE: cmd.rm_rd = 1'b1;
            ffha_pkg::S_REMOVE_WAIT: cmd.rm_wr = 1'b1;
            ffha_pkg::S_DONE: cmd.finish = 1'b1;
            default: cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) out_valid_next = 1'b0;
        if (cmd.finish) out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_INIT;
            out_valid_reg <= 1'b0;
            merged_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            merged_reg <= merged_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: a block table walked entry by entry, with split
// and merge. Each table entry scanned passes through a read state and a wait
// state, as does each entry shifted on a split or removed on a merge, since
// the table RAM has a single read address and registered read data. A
// configuration write rebuilds the table. One item is in flight at a time;
// the next is taken only after the result has been accepted.
`default_nettype none
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    ffha_req_if.sink         req,
    ffha_rsp_if.source       rsp
);
    ffha_pkg::cmd_t  cmd;
    ffha_pkg::stat_t stat;

    ffha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .stat(stat), .cmd(cmd));

    ffha_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_kind(req.kind), .in_request_size(req.request_size),
        .in_alignment(req.alignment), .in_release_addr(req.release_addr),
        .res_status(rsp.status), .res_block_addr(rsp.block_addr),
        .res_used_bytes(rsp.used_bytes), .res_free_bytes(rsp.free_bytes));
endmodule
`default_nettype wire

// ===== verif/tb_first_fit_heap_allocator.sv =====
// Testbench: first-fit heap allocator checked against a block-table predictor.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
    localparam int MAXB = ffha_pkg::MAX_BLOCKS_DEF;
    localparam int HDR  = ffha_pkg::HEADER_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8 * MAXB + 50;

    typedef struct packed {
        logic        kind;
        logic [31:0] size;
        logic [12:0] align;
        logic [31:0] addr;
    } heap_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] addr;
        logic [31:0] used;
        logic [31:0] free;
    } heap_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = ffha_pkg::REG_HEAP_START;
    logic [31:0] cfg_data = '0;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #5 clk = ~clk;

    // shadow of the block table
    logic [31:0] tbl_start [MAXB];
    logic [31:0] tbl_size  [MAXB];
    logic        tbl_busy  [MAXB];
    int          tbl_count;
    logic [31:0] used_total;
    logic [31:0] heap_base;
    logic [31:0] heap_bytes;

    heap_req_t pending_q [$];
    heap_rsp_t expected_q [$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  mismatches = 0;
    int  results_seen = 0;
    int  alloc_ok = 0;
    int  free_ok = 0;
    int  splits_skipped = 0;
    int  max_count = 0;

    function automatic void table_rebuild();
        for (int i = 0; i < MAXB; i++)
        begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_busy[i]  = 1'b0;
        end
        tbl_start[0] = heap_base + HDR;
        tbl_size[0]  = (heap_bytes >= HDR) ? heap_bytes - HDR : '0;
        tbl_count    = 1;
        used_total   = '0;
    endfunction

    function automatic void table_drop(int j);
        for (int k = j; k < tbl_count - 1; k++)
        begin
            tbl_start[k] = tbl_start[k + 1];
            tbl_size[k]  = tbl_size[k + 1];
            tbl_busy[k]  = tbl_busy[k + 1];
        end
        tbl_count--;
    endfunction

    function automatic heap_rsp_t predict_request(heap_req_t r);
        heap_rsp_t   res;
        logic [33:0] want;
        logic [33:0] need;
        logic [31:0] am;
        int          hit;
        int          i;
        res = '0;
        res.status = ffha_pkg::ST_NOTFOUND;
        if (r.kind == ffha_pkg::KIND_ALLOC)
        begin
            want = {2'b0, r.size} + ((r.align != 0) ? {21'b0, r.align} - 34'd1 : 34'd0);
            if (want == 0)
                res.status = ffha_pkg::ST_ZERO;
            else
            begin
                need = (want + 34'd3) & ~34'd3;
                hit = -1;
                for (i = 0; i < tbl_count; i++)
                    if (!tbl_busy[i] && {2'b0, tbl_size[i]} >= need)
                    begin
                        hit = i;
                        break;
                    end
                res.status = ffha_pkg::ST_NOFIT;
                if (hit >= 0)
                begin
                    if ({2'b0, tbl_size[hit]} > need + HDR)
                    begin
                        if (tbl_count < MAXB)
                        begin
                            for (int k = tbl_count - 1; k > hit; k--)
                            begin
                                tbl_start[k + 1] = tbl_start[k];
                                tbl_size[k + 1]  = tbl_size[k];
                                tbl_busy[k + 1]  = tbl_busy[k];
                            end
                            tbl_start[hit + 1] = tbl_start[hit] + need[31:0] + HDR;
                            tbl_size[hit + 1]  = tbl_size[hit] - need[31:0] - HDR;
                            tbl_busy[hit + 1]  = 1'b0;
                            tbl_size[hit]      = need[31:0];
                            tbl_count++;
                        end
                        else
                            splits_skipped++;
                    end
                    tbl_busy[hit] = 1'b1;
                    used_total += tbl_size[hit];
                    am = {19'b0, r.align} - 32'd1;
                    res.addr = (r.align != 0) ? ((tbl_start[hit] + am) & ~am) : tbl_start[hit];
                    res.status = ffha_pkg::ST_OK;
                    alloc_ok++;
                end
            end
        end
        else if (r.addr != 0)
        begin
            hit = -1;
            for (i = 0; i < tbl_count; i++)
                if (tbl_start[i] == r.addr)
                begin
                    hit = i;
                    break;
                end
            if (hit >= 0 && tbl_busy[hit])
            begin
                tbl_busy[hit] = 1'b0;
                used_total -= tbl_size[hit];
                if (hit > 0 && !tbl_busy[hit - 1])
                begin
                    tbl_size[hit - 1] += tbl_size[hit] + HDR;
                    table_drop(hit);
                    hit--;
                end
                if (hit + 1 < tbl_count && !tbl_busy[hit + 1])
                begin
                    tbl_size[hit] += tbl_size[hit + 1] + HDR;
                    table_drop(hit + 1);
                end
                res.status = ffha_pkg::ST_OK;
                free_ok++;
            end
        end
        if (tbl_count > max_count)
            max_count = tbl_count;
        res.used = used_total;
        res.free = heap_bytes - used_total;
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    heap_req_t it;
                    it = pending_q.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.kind         <= it.kind;
                    req_ch.request_size <= it.size;
                    req_ch.alignment    <= it.align;
                    req_ch.release_addr <= it.addr;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                expected_q.push_back(predict_request({req_ch.kind, req_ch.request_size,
                                                      req_ch.alignment, req_ch.release_addr}));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                heap_rsp_t e;
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with no transaction outstanding: st=%0d addr=%h",
                                 rsp_ch.status, rsp_ch.block_addr);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp_ch.status !== e.status || rsp_ch.block_addr !== e.addr ||
                        rsp_ch.used_bytes !== e.used || rsp_ch.free_bytes !== e.free)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR: result %0d exp st=%0d addr=%h used=%h free=%h",
                                     results_seen, e.status, e.addr, e.used, e.free);
                            $display("       got st=%0d addr=%h used=%h free=%h",
                                     rsp_ch.status, rsp_ch.block_addr, rsp_ch.used_bytes,
                                     rsp_ch.free_bytes);
                        end
                    end
                end
            end
        end
    end

    task automatic push_alloc(logic [31:0] sz, logic [12:0] al);
        pending_q.push_back({ffha_pkg::KIND_ALLOC, sz, al, $urandom()});
    endtask

    task automatic push_free(logic [31:0] a);
        pending_q.push_back({ffha_pkg::KIND_FREE, $urandom(), 13'($urandom_range(0, 4096)), a});
    endtask

    task automatic wait_drain();
        do @(negedge clk);
        while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == ffha_pkg::REG_HEAP_START)
            heap_base = val;
        else
            heap_bytes = val;
        table_rebuild();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_heap(logic [31:0] base, logic [31:0] bytes);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write(ffha_pkg::REG_HEAP_START, base);
        cfg_write(ffha_pkg::REG_HEAP_SIZE, bytes);
    endtask

    function automatic logic [12:0] pick_align();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return '0;
        else if (r < 92)
            return 13'(1 << $urandom_range(0, 12));
        return 13'($urandom_range(0, 4096));
    endfunction

    task automatic random_phase(int n, int max_log, logic [31:0] base, logic [31:0] bytes,
                                int mode);
        int r;
        int k;
        set_heap(base, bytes);
        send_idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 33 : 0;
        recv_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 33 : 0;
        for (int i = 0; i < n; i++)
        begin
            while (pending_q.size() >= 4)
                @(negedge clk);
            if (i == n / 2 && mode == 1)
                wait_drain();
            r = $urandom_range(99);
            if (r < 55)
                push_alloc($urandom_range(1, 1 << $urandom_range(2, max_log)), pick_align());
            else if (r < 90)
            begin
                k = $urandom_range(0, tbl_count - 1);
                push_free(tbl_busy[k] ? tbl_start[k] : tbl_start[$urandom_range(0, tbl_count - 1)]);
            end
            else if (r < 94)
                push_alloc($urandom(), pick_align());
            else if (r < 97)
                push_free($urandom());
            else
                push_alloc('0, pick_align());
        end
    endtask

    initial
    begin
        logic [31:0] a;
        req_ch.valid        = 1'b0;
        req_ch.kind         = ffha_pkg::KIND_ALLOC;
        req_ch.request_size = '0;
        req_ch.alignment    = '0;
        req_ch.release_addr = '0;
        rsp_ch.ready        = 1'b0;
        heap_base  = '0;
        heap_bytes = '0;
        table_rebuild();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: empty heap
        push_alloc(32'd4, '0);
        push_free(32'h10);
        set_heap(32'h0000_1000, 32'd1024);
        push_alloc('0, '0);
        push_alloc('0, 13'd1);
        push_alloc('0, 13'd4096);
        push_alloc(32'd1, '0);
        push_alloc(32'd13, 13'd8);
        push_alloc(32'd5, 13'd3);
        push_alloc(32'hFFFF_FFFF, '0);
        push_alloc(32'hFFFF_FFFF, 13'd4096);
        push_alloc(32'd100, '0);
        push_alloc(32'd40, '0);
        push_free('0);
        push_free(32'hDEAD_BEEF);
        wait_drain();
        a = tbl_start[1];
        push_free(a);
        push_free(a);
        wait_drain();
        push_free(tbl_start[0]);
        push_free(tbl_start[3]);
        wait_drain();
        push_free(tbl_start[1]);
        push_alloc(32'd2000, '0);
        push_alloc(32'd1007, 13'd1);

        random_phase(330, 4, 32'h0, 32'h600, 0);
        random_phase(300, 31, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1);
        random_phase(60, 6, 32'h8000_0000, 32'd8, 2);
        random_phase(330, 10, $urandom(), 32'd4096, 3);
        random_phase(350, 5, 32'hFFFF_FFFF, 32'h800, 1);
        random_phase(350, 12, $urandom(), 32'h1_0000, 0);

        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_q.size() != 0)
            mismatches++;
        $display("Covered %0d results: %0d grants, %0d frees, peak table %0d entries,",
                 results_seen, alloc_ok, free_ok, max_count);
        $display("%0d grants kept whole on a full table; %0d mismatches.",
                 splits_skipped, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("Timeout with %0d results outstanding", expected_q.size());
        $display("*** FAILED ***");
        $finish;
    end
endmodule
